>>> design/dlsa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dlsa_pkg: shared definitions of the display link sequence/ack engine
// Widths, command and reply codes, register indexes and the beat formats
// that pass between the front, the back and the result queue.
// ----------------------------------------------------------------------------
package dlsa_pkg;

    localparam int ID_W   = 29;
    localparam int LEN_W  = 4;
    localparam int BYTE_W = 8;
    localparam int TICK_W = 16;
    localparam int CNT_W  = 8;

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam int CMD_DEPTH_DEF = 2;
    localparam int RES_DEPTH_DEF = 2;

    localparam int LONG_REPLY_LEN = 6;

    localparam logic [BYTE_W-1:0] CMD_KEEPALIVE = 8'hA3;
    localparam logic [BYTE_W-1:0] CMD_LONG_ALT  = 8'hA0;
    localparam logic [BYTE_W-1:0] SEQ_LIMIT     = 8'h20;
    localparam logic [BYTE_W-1:0] ACK_BASE      = 8'hB0;
    localparam logic [LEN_W-1:0]  FRAME_LEN_MAX = 4'd8;
    localparam logic [LEN_W-1:0]  CTRL_LEN      = 4'd1;
    localparam logic [TICK_W-1:0] RESP_TICKS_RST = 16'd200;

    typedef enum logic [1:0] {
        REQ_SEND      = 2'd0,
        REQ_KEEPALIVE = 2'd1,
        REQ_FRAME     = 2'd2,
        REQ_TICK      = 2'd3
    } req_kind_t;

    typedef enum logic [1:0] {
        REG_RX_ID      = 2'd0,
        REG_TX_ID      = 2'd1,
        REG_RESP_TICKS = 2'd2
    } reg_index_t;

    // Classified input item, as the back consumes it
    typedef struct packed {
        req_kind_t          kind;
        logic               id_match;
        logic [ID_W-1:0]    frame_id;
        logic [LEN_W-1:0]   tx_len;
        logic [BYTE_W-1:0]  base;
        logic               long_cmd;
        logic               len_gt1;
        logic               d0_low;
        logic [BYTE_W-1:0]  d0;
        logic               long_match;
    } cmd_t;

    typedef struct packed {
        logic               tx_valid;
        logic [ID_W-1:0]    tx_id;
        logic [LEN_W-1:0]   tx_len;
        logic [BYTE_W-1:0]  tx_byte0;
        logic               done_res;
        logic               ack_ok;
    } res_t;

    function automatic logic [BYTE_W-1:0] long_reply_byte(input logic [2:0] k);
        logic [BYTE_W-1:0] b;
        case (k)
            3'd0:    b = 8'hA1;
            3'd1:    b = 8'h0F;
            3'd2:    b = 8'h8A;
            3'd3:    b = 8'hFF;
            3'd4:    b = 8'h4A;
            3'd5:    b = 8'hFF;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // x mod 15: 16 is 1 mod 15, so fold the nibbles, then reduce twice
    function automatic logic [3:0] mod15(input logic [CNT_W-1:0] x);
        logic [4:0] s;
        s = {1'b0, x[7:4]} + {1'b0, x[3:0]};
        if (s >= 5'd15) begin
            s = s - 5'd15;
        end
        if (s == 5'd15) begin
            s = 5'd0;
        end
        return s[3:0];
    endfunction

endpackage
`default_nettype wire

>>> design/dlsa_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dlsa_queue: small first-in first-out beat queue
// Circular buffer of registers with a fill count; head shown while not empty.
// ----------------------------------------------------------------------------
module dlsa_queue
    import dlsa_pkg::*;
#(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             rd_en,
    output logic      [WIDTH-1:0] rd_data,
    output logic                  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]  slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              do_wr, do_rd;

    assign full    = (fill_reg == FILL_W'(DEPTH));
    assign empty   = (fill_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule
`default_nettype wire

>>> design/dlsa_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dlsa_front: input side of the engine
// Accept input beats, classify them (id match, length checks, long reply
// compare, command base byte) and hold them in the command queue.
// ----------------------------------------------------------------------------
module dlsa_front
    import dlsa_pkg::*;
#(
    parameter int CMD_DEPTH = CMD_DEPTH_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire logic [1:0]        req_type,
    input  wire logic [ID_W-1:0]   frame_id,
    input  wire logic [LEN_W-1:0]  frame_len,
    input  wire logic [BYTE_W-1:0] data0,
    input  wire logic [BYTE_W-1:0] data1,
    input  wire logic [BYTE_W-1:0] data2,
    input  wire logic [BYTE_W-1:0] data3,
    input  wire logic [BYTE_W-1:0] data4,
    input  wire logic [BYTE_W-1:0] data5,
    input  wire logic [ID_W-1:0]   rx_id,
    output cmd_t                   cmd,
    output logic                   cmd_valid,
    input  wire logic              cmd_ready
);

    logic [BYTE_W-1:0] d [LONG_REPLY_LEN];
    cmd_t              cls;
    logic              cmd_empty;

    assign d[0] = data0;
    assign d[1] = data1;
    assign d[2] = data2;
    assign d[3] = data3;
    assign d[4] = data4;
    assign d[5] = data5;

    always_comb
    begin
        cls.kind     = req_kind_t'(req_type);
        cls.id_match = (frame_id == rx_id);
        cls.frame_id = frame_id;
        cls.tx_len   = (frame_len > FRAME_LEN_MAX) ? FRAME_LEN_MAX : frame_len;
        // a zero-length send carries a zero base byte
        cls.base     = (frame_len != '0) ? data0 : '0;
        cls.long_cmd = (cls.base == CMD_KEEPALIVE) || (cls.base == CMD_LONG_ALT);
        cls.len_gt1  = (frame_len > LEN_W'(1));
        cls.d0_low   = (data0 < SEQ_LIMIT);
        cls.d0       = data0;
        // compare only the bytes the frame carries, up to six
        cls.long_match = 1'b1;
        for (int k = 0; k < LONG_REPLY_LEN; k++)
        begin
            if ((LEN_W'(k) < frame_len) && (d[k] != long_reply_byte(3'(k))))
            begin
                cls.long_match = 1'b0;
            end
        end
    end

    dlsa_queue #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (cls),
        .full    (full),
        .rd_en   (cmd_ready),
        .rd_data (cmd),
        .empty   (cmd_empty)
    );

    assign cmd_valid = !cmd_empty;

endmodule
`default_nettype wire

>>> design/dlsa_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dlsa_back: link state and result side of the engine
// Carry out one classified beat per cycle, while the result queue has room,
// against the request phase and the sequence counters, and queue any result beat for the consumer.
// ----------------------------------------------------------------------------
module dlsa_back
    import dlsa_pkg::*;
#(
    parameter int RES_DEPTH = RES_DEPTH_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cmd_t              cmd,
    input  wire logic              cmd_valid,
    output logic                   cmd_ready,
    input  wire logic [ID_W-1:0]   tx_id_cfg,
    input  wire logic [TICK_W-1:0] resp_ticks,
    input  wire logic              pop,
    output res_t                   res,
    output logic                   empty
);

    typedef enum logic [1:0] {
        PH_IDLE = 2'b01,
        PH_WAIT = 2'b10
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic               exp_long_reg, exp_long_next;
    logic [CNT_W-1:0]   send_cnt_reg, send_cnt_next;
    logic [CNT_W-1:0]   recv_cnt_reg, recv_cnt_next;
    logic [3:0]         recv_mod_reg, recv_mod_next;
    logic [TICK_W-1:0]  wait_ticks_reg, wait_ticks_next;

    logic               res_full;
    logic               consume;
    logic               res_wr;
    res_t               res_new;
    logic [BYTE_W-1:0]  seq_byte;
    logic [CNT_W-1:0]   recv_inc;
    logic [3:0]         recv_inc_mod;
    logic               reply_ok;

    assign cmd_ready = !res_full;
    assign consume   = cmd_valid && !res_full;

    assign seq_byte     = cmd.base + {4'b0000, send_cnt_reg[3:0]};
    assign recv_inc     = recv_cnt_reg + 1'b1;
    assign recv_inc_mod = mod15(recv_inc);
    assign reply_ok     = exp_long_reg ? cmd.long_match
                                       : (cmd.d0 == (ACK_BASE + {4'b0000, recv_mod_reg}));

    always_comb
    begin
        phase_next      = phase_reg;
        exp_long_next   = exp_long_reg;
        send_cnt_next   = send_cnt_reg;
        recv_cnt_next   = recv_cnt_reg;
        recv_mod_next   = recv_mod_reg;
        wait_ticks_next = wait_ticks_reg;
        res_new         = '0;
        res_wr          = 1'b0;
        if (consume)
        begin
            case (cmd.kind)
                REQ_SEND:
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        res_wr           = 1'b1;
                        res_new.tx_valid = 1'b1;
                        res_new.tx_id    = cmd.frame_id;
                        res_new.tx_len   = cmd.tx_len;
                        if (cmd.long_cmd)
                        begin
                            res_new.tx_byte0 = cmd.base;
                            phase_next       = PH_WAIT;
                            exp_long_next    = 1'b1;
                            wait_ticks_next  = '0;
                        end
                        else
                        begin
                            res_new.tx_byte0 = seq_byte;
                            send_cnt_next    = send_cnt_reg + 1'b1;
                            if (seq_byte >= SEQ_LIMIT)
                            begin
                                res_new.done_res = 1'b1;
                                res_new.ack_ok   = 1'b1;
                            end
                            else
                            begin
                                phase_next      = PH_WAIT;
                                exp_long_next   = 1'b0;
                                wait_ticks_next = '0;
                            end
                        end
                    end
                end
                REQ_KEEPALIVE:
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        res_wr           = 1'b1;
                        res_new.tx_valid = 1'b1;
                        res_new.tx_id    = tx_id_cfg;
                        res_new.tx_len   = CTRL_LEN;
                        res_new.tx_byte0 = CMD_KEEPALIVE;
                        phase_next       = PH_WAIT;
                        exp_long_next    = 1'b1;
                        wait_ticks_next  = '0;
                    end
                end
                REQ_FRAME:
                begin
                    if (cmd.id_match)
                    begin
                        if (phase_reg == PH_IDLE)
                        begin
                            if (cmd.len_gt1)
                            begin
                                recv_cnt_next = recv_inc;
                                recv_mod_next = recv_inc_mod;
                                if (cmd.d0_low)
                                begin
                                    res_wr           = 1'b1;
                                    res_new.tx_valid = 1'b1;
                                    res_new.tx_id    = tx_id_cfg;
                                    res_new.tx_len   = CTRL_LEN;
                                    res_new.tx_byte0 = ACK_BASE + {4'b0000, recv_inc_mod};
                                end
                            end
                        end
                        else if (reply_ok)
                        begin
                            res_wr           = 1'b1;
                            res_new.done_res = 1'b1;
                            res_new.ack_ok   = 1'b1;
                            phase_next       = PH_IDLE;
                        end
                    end
                end
                REQ_TICK:
                begin
                    if (phase_reg == PH_WAIT)
                    begin
                        if (wait_ticks_reg >= resp_ticks)
                        begin
                            res_wr           = 1'b1;
                            res_new.done_res = 1'b1;
                            phase_next       = PH_IDLE;
                        end
                        else
                        begin
                            wait_ticks_next = wait_ticks_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                    res_wr = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            exp_long_reg   <= 1'b0;
            send_cnt_reg   <= '0;
            recv_cnt_reg   <= '0;
            recv_mod_reg   <= '0;
            wait_ticks_reg <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            exp_long_reg   <= exp_long_next;
            send_cnt_reg   <= send_cnt_next;
            recv_cnt_reg   <= recv_cnt_next;
            recv_mod_reg   <= recv_mod_next;
            wait_ticks_reg <= wait_ticks_next;
        end
    end

    dlsa_queue #(
        .WIDTH ($bits(res_t)),
        .DEPTH (RES_DEPTH)
    ) u_res_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_wr),
        .wr_data (res_new),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (res),
        .empty   (empty)
    );

endmodule
`default_nettype wire

>>> design/display_link_sequence_ack_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// display_link_sequence_ack_engine: CAN sequence/ack link engine for a display
// Numbers outgoing display commands, tracks acks and long replies, acks
// display frames and times out pending requests on millisecond ticks.
// ----------------------------------------------------------------------------
// The engine takes one beat per clock on the push/full side while full is
// low (send request, keepalive request, received frame or tick) and gives at
// most one result beat per item on the empty/pop side; an accepted beat passes
// through the registered command queue and result queue before its result shows.
// The front classifies each beat and parks it in a command queue
// of CMD_DEPTH entries; the back updates the link state for each beat and
// parks results in a queue of RES_DEPTH entries. Sustained rate is one item
// per cycle; the back holds only while the result queue is full, and full
// rises only once the command queue has filled behind it. Items that cause
// no result (ticks that do not time out, ignored frames, requests during a
// wait) leave nothing in the result queue.
// Program display_rx_id (0x0), display_tx_id (0x4) and response_ticks (0x8)
// through the APB port while the engine is idle; all three read back.
// ----------------------------------------------------------------------------
module display_link_sequence_ack_engine
    import dlsa_pkg::*;
#(
    parameter int CMD_DEPTH = CMD_DEPTH_DEF,
    parameter int RES_DEPTH = RES_DEPTH_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    // configuration port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    // input items
    input  wire logic               push,
    output logic                    full,
    input  wire logic [1:0]         req_type,
    input  wire logic [ID_W-1:0]    frame_id,
    input  wire logic [LEN_W-1:0]   frame_len,
    input  wire logic [BYTE_W-1:0]  data0,
    input  wire logic [BYTE_W-1:0]  data1,
    input  wire logic [BYTE_W-1:0]  data2,
    input  wire logic [BYTE_W-1:0]  data3,
    input  wire logic [BYTE_W-1:0]  data4,
    input  wire logic [BYTE_W-1:0]  data5,
    // result items
    output logic                    empty,
    input  wire logic               pop,
    output logic                    tx_valid,
    output logic      [ID_W-1:0]    tx_id,
    output logic      [LEN_W-1:0]   tx_len,
    output logic      [BYTE_W-1:0]  tx_byte0,
    output logic                    done_res,
    output logic                    ack_ok
);

    logic [ID_W-1:0]   rx_id_reg;
    logic [ID_W-1:0]   tx_id_reg;
    logic [TICK_W-1:0] resp_ticks_reg;
    logic              cfg_wr;
    reg_index_t        cfg_sel;

    cmd_t              cmd;
    logic              cmd_valid;
    logic              cmd_ready;
    res_t              res;

    // ---------------- configuration registers ----------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_sel = reg_index_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_id_reg      <= '0;
            tx_id_reg      <= '0;
            resp_ticks_reg <= RESP_TICKS_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_sel)
                REG_RX_ID:      rx_id_reg      <= pwdata[ID_W-1:0];
                REG_TX_ID:      tx_id_reg      <= pwdata[ID_W-1:0];
                REG_RESP_TICKS: resp_ticks_reg <= pwdata[TICK_W-1:0];
                default:        rx_id_reg      <= rx_id_reg;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_sel)
            REG_RX_ID:      prdata = PDATA_W'(rx_id_reg);
            REG_TX_ID:      prdata = PDATA_W'(tx_id_reg);
            REG_RESP_TICKS: prdata = PDATA_W'(resp_ticks_reg);
            default:        prdata = '0;
        endcase
    end

    // ---------------- front: accept and classify ----------------
    dlsa_front #(
        .CMD_DEPTH (CMD_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .req_type  (req_type),
        .frame_id  (frame_id),
        .frame_len (frame_len),
        .data0     (data0),
        .data1     (data1),
        .data2     (data2),
        .data3     (data3),
        .data4     (data4),
        .data5     (data5),
        .rx_id     (rx_id_reg),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready)
    );

    // ---------------- back: link state and results ----------------
    dlsa_back #(
        .RES_DEPTH (RES_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .tx_id_cfg  (tx_id_reg),
        .resp_ticks (resp_ticks_reg),
        .pop        (pop),
        .res        (res),
        .empty      (empty)
    );

    assign tx_valid = res.tx_valid;
    assign tx_id    = res.tx_id;
    assign tx_len   = res.tx_len;
    assign tx_byte0 = res.tx_byte0;
    assign done_res = res.done_res;
    assign ack_ok   = res.ack_ok;

    // ---------------- assertions ----------------
    // Every queued result either transmits or finishes a request
    a_no_blank_result: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (tx_valid || done_res))
        else $error("result beat neither transmits nor finishes");

    // A timeout never travels with a frame
    a_timeout_alone: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && done_res && !ack_ok) |-> !tx_valid)
        else $error("timeout result carries a frame");

    // Frame lengths are saturated to a CAN payload
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && tx_valid) |-> (tx_len <= FRAME_LEN_MAX))
        else $error("transmit length above eight");

    // A result with nothing to send shows clean frame fields
    a_clean_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !tx_valid) |-> ((tx_id == '0) && (tx_len == '0) && (tx_byte0 == '0)))
        else $error("stale frame fields on a finish-only result");

endmodule
`default_nettype wire

>>> tb/testbench.sv
`default_nettype none
// ----------------------------------------------------------------------------
// testbench: display link sequence/ack engine
// Feeds send, keepalive, display frame and tick beats through the push/full
// side, predicts every transmit/done beat with an in-bench model of the link
// state, and checks each beat popped from the result side against it.
// ----------------------------------------------------------------------------
module testbench;
    import dlsa_pkg::*;

    // What the link is waiting for after a request goes out
    typedef enum logic [1:0] {
        REPLY_NONE,
        REPLY_LONG,
        REPLY_ACK
    } reply_kind_t;

    // One input beat; fill_reply asks the driver to shape the data into the
    // reply the link awaits at the moment the beat is launched
    typedef struct packed {
        req_kind_t              kind;
        logic [ID_W-1:0]        id;
        logic [LEN_W-1:0]       len;
        logic [5:0][BYTE_W-1:0] data;
        logic                   fill_reply;
    } link_item_t;

    localparam int DATA_W = 6 * BYTE_W;
    localparam logic [ID_W-1:0] ID_ALL = '1;
    localparam logic [5:0][BYTE_W-1:0] LONG_REPLY =
        {8'hFF, 8'h4A, 8'hFF, 8'h8A, 8'h0F, 8'hA1};

    logic clk;
    logic rst_n = 1'b0;

    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [PADDR_W-1:0] paddr   = '0;
    logic [PDATA_W-1:0] pwdata  = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    logic       push = 1'b0;
    logic       full;
    link_item_t in_beat = '0;

    logic              empty;
    logic              pop = 1'b0;
    logic              tx_valid;
    logic [ID_W-1:0]   tx_id;
    logic [LEN_W-1:0]  tx_len;
    logic [BYTE_W-1:0] tx_byte0;
    logic              done_res;
    logic              ack_ok;

    // Register copies as last written
    logic [ID_W-1:0]   cfg_rx_id      = '0;
    logic [ID_W-1:0]   cfg_tx_id      = '0;
    logic [TICK_W-1:0] cfg_resp_ticks = RESP_TICKS_RST;

    // Link state as the engine should hold it
    bit                link_busy  = 1'b0;
    reply_kind_t       awaited    = REPLY_NONE;
    logic [CNT_W-1:0]  seq_tx     = '0;
    logic [CNT_W-1:0]  seq_rx     = '0;
    logic [TICK_W-1:0] wait_count = '0;

    link_item_t pending_items[$];
    res_t       frames_due[$];

    int items_queued   = 0;
    int items_accepted = 0;
    int error_count    = 0;

    bit in_taken  = 1'b0;
    bit out_taken = 1'b0;
    int in_gap    = 0;
    int in_calm   = 0;
    int out_gap   = 0;
    int out_calm  = 0;

    display_link_sequence_ack_engine u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .push     (push),
        .full     (full),
        .req_type (in_beat.kind),
        .frame_id (in_beat.id),
        .frame_len(in_beat.len),
        .data0    (in_beat.data[0]),
        .data1    (in_beat.data[1]),
        .data2    (in_beat.data[2]),
        .data3    (in_beat.data[3]),
        .data4    (in_beat.data[4]),
        .data5    (in_beat.data[5]),
        .empty    (empty),
        .pop      (pop),
        .tx_valid (tx_valid),
        .tx_id    (tx_id),
        .tx_len   (tx_len),
        .tx_byte0 (tx_byte0),
        .done_res (done_res),
        .ack_ok   (ack_ok)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard stop in case a beat never shows up
    initial
    begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------
    // Link state prediction
    // ------------------------------------------------------------------

    // Ack code the display expects for the current receive count
    function automatic logic [BYTE_W-1:0] ack_code();
        return ACK_BASE + BYTE_W'(seq_rx % 15);
    endfunction

    function automatic void open_wait(input reply_kind_t kind);
        link_busy  = 1'b1;
        awaited    = kind;
        wait_count = '0;
    endfunction

    // Advance the link state by one accepted beat; return 1 with the
    // expected result beat when the beat causes one
    function automatic bit predict_link(input link_item_t it, output res_t r);
        logic [BYTE_W-1:0] b0;
        bit                ok;
        r = '0;
        case (it.kind)
            REQ_SEND, REQ_KEEPALIVE:
            begin
                // Requests during a wait are dropped
                if (link_busy)
                    return 1'b0;
                r.tx_valid = 1'b1;
                if (it.kind == REQ_KEEPALIVE)
                begin
                    r.tx_id    = cfg_tx_id;
                    r.tx_len   = CTRL_LEN;
                    r.tx_byte0 = CMD_KEEPALIVE;
                    open_wait(REPLY_LONG);
                    return 1'b1;
                end
                r.tx_id  = it.id;
                r.tx_len = (it.len > FRAME_LEN_MAX) ? FRAME_LEN_MAX : it.len;
                // An empty send numbers a zero byte
                b0 = (it.len != '0) ? it.data[0] : '0;
                if (b0 == CMD_KEEPALIVE || b0 == CMD_LONG_ALT)
                begin
                    r.tx_byte0 = b0;
                    open_wait(REPLY_LONG);
                    return 1'b1;
                end
                b0         = b0 + BYTE_W'(seq_tx[3:0]);
                seq_tx     = seq_tx + 1'b1;
                r.tx_byte0 = b0;
                if (b0 >= SEQ_LIMIT)
                begin
                    // No ack awaited: finish at once
                    r.done_res = 1'b1;
                    r.ack_ok   = 1'b1;
                    awaited    = REPLY_NONE;
                    return 1'b1;
                end
                open_wait(REPLY_ACK);
                return 1'b1;
            end
            REQ_FRAME:
            begin
                if (it.id != cfg_rx_id)
                    return 1'b0;
                if (!link_busy)
                begin
                    if (it.len > 4'd1)
                    begin
                        seq_rx = seq_rx + 1'b1;
                        if (it.data[0] < SEQ_LIMIT)
                        begin
                            r.tx_valid = 1'b1;
                            r.tx_id    = cfg_tx_id;
                            r.tx_len   = CTRL_LEN;
                            r.tx_byte0 = ack_code();
                            return 1'b1;
                        end
                    end
                    return 1'b0;
                end
                if (awaited == REPLY_LONG)
                begin
                    // Compare only as many bytes as the frame carries
                    ok = 1'b1;
                    for (int k = 0; k < LONG_REPLY_LEN; k++)
                        if (k < it.len && it.data[k] != LONG_REPLY[k])
                            ok = 1'b0;
                end
                else
                    ok = (it.data[0] == ack_code());
                // A wrong reply is swallowed and the wait goes on
                if (!ok)
                    return 1'b0;
                link_busy  = 1'b0;
                awaited    = REPLY_NONE;
                r.done_res = 1'b1;
                r.ack_ok   = 1'b1;
                return 1'b1;
            end
            default:
            begin
                if (!link_busy)
                    return 1'b0;
                if (wait_count >= cfg_resp_ticks)
                begin
                    link_busy  = 1'b0;
                    awaited    = REPLY_NONE;
                    r.done_res = 1'b1;
                    return 1'b1;
                end
                wait_count = wait_count + 1'b1;
                return 1'b0;
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Mostly short idles, now and then a long one or a stretch of none
    function automatic int pick_gap(inout int calm);
        int roll;
        if (calm > 0)
        begin
            calm = calm - 1;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 4)
        begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Legal lengths mostly, oversized ones now and then
    function automatic logic [LEN_W-1:0] rand_len();
        if ($urandom_range(0, 4) == 0)
            return LEN_W'($urandom_range(9, 15));
        return LEN_W'($urandom_range(0, 8));
    endfunction

    task automatic add_item(input req_kind_t kind, input logic [ID_W-1:0] id,
                            input logic [LEN_W-1:0] len, input logic [BYTE_W-1:0] d0,
                            input bit fill);
        link_item_t it;
        it.kind       = kind;
        it.id         = id;
        it.len        = len;
        it.data       = DATA_W'({$urandom, $urandom});
        it.data[0]    = d0;
        it.fill_reply = fill;
        pending_items.push_back(it);
        items_queued += 1;
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [PDATA_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            REG_RX_ID:      cfg_rx_id      = value[ID_W-1:0];
            REG_TX_ID:      cfg_tx_id      = value[ID_W-1:0];
            REG_RESP_TICKS: cfg_resp_ticks = value[TICK_W-1:0];
            default:        ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic configure(input logic [ID_W-1:0] rx_id, input logic [ID_W-1:0] tx_id,
                             input logic [TICK_W-1:0] ticks);
        write_reg(REG_RX_ID, PDATA_W'(rx_id));
        write_reg(REG_TX_ID, PDATA_W'(tx_id));
        write_reg(REG_RESP_TICKS, PDATA_W'(ticks));
    endtask

    // Let every queued beat in, every result out, then settle the engine
    task automatic drain();
        while (items_accepted != items_queued || frames_due.size() != 0)
            @(negedge clk);
        repeat (12) @(negedge clk);
    endtask

    // Ticks after a request, sometimes enough to time it out, then the reply
    task automatic queue_reply_wait();
        int n;
        if (cfg_resp_ticks < 24 && $urandom_range(0, 3) == 0)
            n = cfg_resp_ticks + 1 + $urandom_range(0, 2);
        else
            n = $urandom_range(0, (cfg_resp_ticks < 6) ? cfg_resp_ticks : 6);
        repeat (n) add_item(REQ_TICK, ID_W'($urandom), rand_len(), BYTE_W'($urandom), 1'b0);
        if ($urandom_range(0, 3) == 0)
            add_item(REQ_FRAME, cfg_rx_id, rand_len(), BYTE_W'($urandom), 1'b0);
        add_item(REQ_FRAME, cfg_rx_id, rand_len(), BYTE_W'($urandom), 1'b1);
    endtask

    task automatic queue_link_traffic(input int count);
        int                stop_at;
        int                roll;
        logic [BYTE_W-1:0] base;
        stop_at = items_queued + count;
        while (items_queued < stop_at)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 40)
            begin
                case ($urandom_range(0, 4))
                    0:       base = CMD_KEEPALIVE;
                    1:       base = CMD_LONG_ALT;
                    2, 3:    base = BYTE_W'($urandom_range(0, SEQ_LIMIT - 1));
                    default: base = BYTE_W'($urandom);
                endcase
                add_item(REQ_SEND, ID_W'($urandom), rand_len(), base, 1'b0);
                queue_reply_wait();
            end
            else if (roll < 55)
            begin
                add_item(REQ_KEEPALIVE, ID_W'($urandom), rand_len(), BYTE_W'($urandom), 1'b0);
                queue_reply_wait();
            end
            else if (roll < 80)
                add_item(REQ_FRAME, cfg_rx_id, rand_len(),
                         $urandom_range(0, 1) ? BYTE_W'($urandom_range(0, SEQ_LIMIT - 1))
                                              : BYTE_W'($urandom),
                         1'b0);
            else
                add_item(req_kind_t'($urandom_range(0, 3)),
                         $urandom_range(0, 1) ? cfg_rx_id : ID_W'($urandom),
                         rand_len(), BYTE_W'($urandom), 1'b0);
        end
    endtask

    // ------------------------------------------------------------------
    // Input driver: launch beats at the falling edge, hold until taken
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        link_item_t nxt;
        if (rst_n && !(push && !in_taken))
        begin
            if (in_gap > 0)
            begin
                in_gap = in_gap - 1;
                push <= 1'b0;
            end
            else if (pending_items.size() != 0)
            begin
                nxt = pending_items.pop_front();
                // Shape a reply beat from the state left by the previous beat
                if (nxt.fill_reply && link_busy)
                begin
                    if (awaited == REPLY_LONG)
                        nxt.data = LONG_REPLY;
                    else
                        nxt.data[0] = ack_code();
                end
                in_beat <= nxt;
                push    <= 1'b1;
                in_gap   = pick_gap(in_calm);
            end
            else
                push <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Result side: drop pop for random stretches
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_taken)
                out_gap = pick_gap(out_calm);
            if (out_gap > 0)
            begin
                out_gap = out_gap - 1;
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            error_count += 1;
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor: check popped beats first, then predict the pushed beat
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        res_t want;
        out_taken = rst_n && pop && !empty;
        in_taken  = rst_n && push && !full;
        if (out_taken)
        begin
            if (frames_due.size() == 0)
            begin
                $display("%0t: result beat with nothing expected, actual tx_byte0 %0h",
                         $time, tx_byte0);
                error_count += 1;
            end
            else
            begin
                want = frames_due.pop_front();
                check_field("tx_valid", 32'(want.tx_valid), 32'(tx_valid));
                check_field("tx_id", 32'(want.tx_id), 32'(tx_id));
                check_field("tx_len", 32'(want.tx_len), 32'(tx_len));
                check_field("tx_byte0", 32'(want.tx_byte0), 32'(tx_byte0));
                check_field("done_res", 32'(want.done_res), 32'(done_res));
                check_field("ack_ok", 32'(want.ack_ok), 32'(ack_ok));
            end
        end
        if (in_taken)
        begin
            items_accepted += 1;
            if (predict_link(in_beat, want))
                frames_due.push_back(want);
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // Directed pass: alternating id bits, a two-tick timeout
        configure(29'h1555_5555, 29'h0AAA_AAAA, 16'd2);
        add_item(REQ_TICK, '0, '0, '0, 1'b0);                      // tick with no request
        add_item(REQ_FRAME, cfg_rx_id, 4'd2, 8'h05, 1'b0);         // low byte: acked
        add_item(REQ_FRAME, cfg_rx_id, 4'd1, 8'h05, 1'b0);         // one byte: not counted
        add_item(REQ_FRAME, cfg_rx_id, 4'd8, 8'hFF, 1'b0);         // counted, no ack
        add_item(REQ_FRAME, ~cfg_rx_id, 4'd4, 8'h00, 1'b0);        // foreign id
        add_item(REQ_SEND, ID_ALL, 4'd0, 8'h7E, 1'b0);             // empty send numbers zero
        add_item(REQ_KEEPALIVE, '0, '0, '0, 1'b0);                 // dropped during wait
        add_item(REQ_SEND, '0, 4'd5, 8'h40, 1'b0);                 // dropped during wait
        add_item(REQ_FRAME, cfg_rx_id, 4'd2, 8'h11, 1'b0);         // wrong ack swallowed
        add_item(REQ_FRAME, cfg_rx_id, 4'd1, 8'h00, 1'b1);         // right ack
        add_item(REQ_SEND, 29'h0123_4567, 4'd15, 8'h30, 1'b0);     // oversized, no ack
        add_item(REQ_SEND, 29'h0765_4321, 4'd3, CMD_KEEPALIVE, 1'b0);
        repeat (3) add_item(REQ_TICK, '0, '0, '0, 1'b0);           // third tick times out
        add_item(REQ_KEEPALIVE, '0, '0, '0, 1'b0);
        add_item(REQ_FRAME, cfg_rx_id, 4'd0, 8'h00, 1'b0);         // empty frame matches
        add_item(REQ_SEND, ID_ALL, 4'd8, CMD_LONG_ALT, 1'b0);
        add_item(REQ_FRAME, cfg_rx_id, 4'd8, 8'h00, 1'b1);         // full long reply
        add_item(REQ_KEEPALIVE, '0, '0, '0, 1'b0);
        add_item(REQ_FRAME, cfg_rx_id, 4'd3, 8'hA1, 1'b0);         // partial reply, bad tail
        add_item(REQ_FRAME, cfg_rx_id, 4'd3, 8'h00, 1'b1);         // short matching reply
        add_item(REQ_SEND, ID_ALL, 4'd1, 8'hFF, 1'b0);             // numbering wraps low
        add_item(REQ_FRAME, cfg_rx_id, 4'd2, 8'h00, 1'b1);
        drain();

        // Random passes over extreme and ordinary settings
        configure('0, ID_ALL, 16'd0);
        queue_link_traffic(100);
        drain();
        configure(ID_ALL, '0, 16'hFFFF);
        queue_link_traffic(100);
        drain();
        configure(ID_W'($urandom), ID_W'($urandom), TICK_W'($urandom_range(1, 8)));
        queue_link_traffic(100);
        drain();
        configure(ID_W'($urandom), ID_W'($urandom), TICK_W'($urandom_range(3, 20)));
        queue_link_traffic(100);
        drain();

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
`default_nettype wire
